// ===== hdl/otm_pkg.sv =====
// ----------------------------------------------------------------------------
// otm_pkg: shared types and constants of the overspeed trip monitor
// Field widths, register indexes, status codes, sequencer states and divider structs.
// ----------------------------------------------------------------------------
package otm_pkg;

   localparam int SpeedW = 20;
   localparam int TicksW = 24;
   localparam int TimerW = 32;
   localparam int ClockW = 28;
   localparam int AccelW = 32;
   localparam int AlimW  = 31;
   localparam int CsrW   = 32;
   localparam int CsrIdxW = 3;
   // magnitude * clock is at most 20 + 28 bits
   localparam int ProdW  = 48;
   // divisor is ticks * 32
   localparam int DenW   = 37;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_OVERSPEED  = 3'd0,
      CSR_ALARM      = 3'd1,
      CSR_SPEED_FAIL = 3'd2,
      CSR_ACCEL      = 3'd3,
      CSR_CLOCK      = 3'd4,
      CSR_WINDOW     = 3'd5,
      CSR_RANGE      = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_NORMAL  = 2'd0,
      STATUS_ALARM   = 2'd1,
      STATUS_TRIPPED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MEAN,
      ST_AVG,
      ST_DIVIDE,
      ST_CHECK,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic neg;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

// ===== hdl/otm_if.sv =====
// ----------------------------------------------------------------------------
// otm_req_if / otm_rsp_if: valid/ready channels of the monitor
// One beat carries one update on the request side, one result on the other.
// ----------------------------------------------------------------------------
interface otm_req_if;
   logic                         valid;
   logic                         ready;
   logic [otm_pkg::SpeedW-1:0]   sample_low_range;
   logic [otm_pkg::SpeedW-1:0]   sample_high_range;
   logic [otm_pkg::TicksW-1:0]   elapsed_ticks;
   logic                         powerup_trip;
   modport source (output valid, sample_low_range, sample_high_range,
                   elapsed_ticks, powerup_trip, input ready);
   modport sink   (input valid, sample_low_range, sample_high_range,
                   elapsed_ticks, powerup_trip, output ready);
endinterface

interface otm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [otm_pkg::SpeedW-1:0]   average_speed;
   logic signed [otm_pkg::AccelW-1:0] acceleration;
   logic                         accel_updated;
   logic                         trip;
   logic                         overspeed_flag;
   logic                         overaccel_flag;
   logic                         speed_fail_flag;
   logic                         alarm_flag;
   logic [1:0]                   status;
   modport source (output valid, average_speed, acceleration, accel_updated, trip,
                   overspeed_flag, overaccel_flag, speed_fail_flag, alarm_flag,
                   status, input ready);
   modport sink   (input valid, average_speed, acceleration, accel_updated, trip,
                   overspeed_flag, overaccel_flag, speed_fail_flag, alarm_flag,
                   status, output ready);
endinterface

// ===== hdl/overspeed_trip_monitor.sv =====
// ----------------------------------------------------------------------------
// overspeed_trip_monitor: averaged speed, acceleration and trip latching
// Top level: sequencer, register file, ring memory and divider.
// ----------------------------------------------------------------------------
// An update passes from the accepted request beat through ST_READ, ST_MEAN,
// ST_AVG and ST_DIVIDE to ST_CHECK, which loads the result beat; when the
// acceleration window closes on that update, ST_OUT waits in front of
// ST_CHECK for the restoring divider, one quotient bit per cycle over 48
// bits. The mean is formed by a reciprocal multiplication in a state of its
// own. After reset the ring memory is cleared entry by entry before the first
// request beat is taken; configuration writes are taken at any time. The
// 100-entry sample ring sits in a single-port-read memory whose old entry is
// read, subtracted from the running sum and overwritten. The result stays in
// an output register until taken; the next request beat may be accepted
// while it waits, and its result is held back until the waiting one is gone.
module overspeed_trip_monitor #(
   parameter int WINDOW_LEN = 100
) (
   input  logic                              clock,
   input  logic                              reset,
   otm_req_if.sink                           req,
   otm_rsp_if.source                         rsp,
   input  logic                              csr_write,
   input  logic [otm_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [otm_pkg::CsrW-1:0]          csr_data
);
   localparam int AW   = $clog2(WINDOW_LEN);
   localparam int SumW = otm_pkg::SpeedW + $clog2(WINDOW_LEN + 1);
   localparam int SW   = otm_pkg::SpeedW;
   // floor(sum / WINDOW_LEN) as (sum * Recip) >> RecK, exact for every sum
   localparam int RecK = SumW + $clog2(WINDOW_LEN);
   localparam int RecW = SumW + 2;
   localparam int AvgW = SumW + RecW;
   localparam longint unsigned Recip =
      ((64'd1 << RecK) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);

   // configuration registers
   logic [SW-1:0]                overspeed_limit_ff, alarm_limit_ff;
   logic [SW-1:0]                speed_fail_limit_ff, range_switch_ff;
   logic [otm_pkg::AlimW-1:0]    accel_limit_ff;
   logic [otm_pkg::ClockW-1:0]   clock_hz_ff;
   logic [otm_pkg::TimerW-1:0]   window_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         overspeed_limit_ff  <= SW'(1048575);
         alarm_limit_ff      <= SW'(1048575);
         speed_fail_limit_ff <= '0;
         accel_limit_ff      <= 31'h7FFF_FFFF;
         clock_hz_ff         <= 28'd120000000;
         window_ticks_ff     <= 32'd5000000;
         range_switch_ff     <= SW'(400000);
      end else if (csr_write) begin
         unique case (csr_index)
            otm_pkg::CSR_OVERSPEED:  overspeed_limit_ff  <= csr_data[SW-1:0];
            otm_pkg::CSR_ALARM:      alarm_limit_ff      <= csr_data[SW-1:0];
            otm_pkg::CSR_SPEED_FAIL: speed_fail_limit_ff <= csr_data[SW-1:0];
            otm_pkg::CSR_ACCEL:      accel_limit_ff      <= csr_data[otm_pkg::AlimW-1:0];
            otm_pkg::CSR_CLOCK:      clock_hz_ff         <= csr_data[otm_pkg::ClockW-1:0];
            otm_pkg::CSR_WINDOW:     window_ticks_ff     <= csr_data;
            otm_pkg::CSR_RANGE:      range_switch_ff     <= csr_data[SW-1:0];
            default: ;
         endcase
      end
   end

   // state
   otm_pkg::state_type state_ff, state_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic [SumW-1:0]           sum_ff, sum_in;
   logic [SW-1:0]             mean_ff, mean_in;
   logic                      phase_ff, phase_in;
   logic [SW-1:0]             snap_ff, snap_in;
   logic [otm_pkg::TimerW-1:0] timer_ff, timer_in;
   logic signed [otm_pkg::AccelW-1:0] accel_ff, accel_in;
   logic                      os_ff, os_in, oa_ff, oa_in, sf_ff, sf_in, al_ff, al_in;
   logic [1:0]                status_ff, status_in;
   logic                      upd_ff, upd_in;
   // captured request beat
   logic [SW-1:0]             sample_ff, sample_in;
   logic [otm_pkg::TicksW-1:0] ticks_ff, ticks_in;
   logic                      pu_ff, pu_in;
   // product register in front of the divider
   logic [otm_pkg::ProdW-1:0] prod_ff, prod_in;
   logic                      neg_ff, neg_in;
   // output register
   logic                      rsp_valid_ff, rsp_valid_in;

   logic [SW-1:0]             ring_rd;
   logic                      ring_we;
   logic                      clear_done;
   otm_pkg::div_ctl_type      div_ctl;
   otm_pkg::div_sts_type      div_sts;
   logic signed [otm_pkg::AccelW-1:0] div_result;

   logic [otm_pkg::TimerW:0]  tsum;
   logic [SW-1:0]             dmag;
   logic [otm_pkg::AccelW-1:0] amag;
   logic [AvgW-1:0]           avg_prod;
   logic                      trip_now;

   otm_ring #(.Depth(WINDOW_LEN)) u_ring (
      .clock(clock), .reset(reset),
      .rd_addr(idx_ff), .rd_data(ring_rd),
      .wr_en(ring_we), .wr_addr(idx_ff), .wr_data(sample_ff),
      .clear_done(clear_done)
   );

   otm_div u_div (
      .clock(clock), .reset(reset), .ctl(div_ctl),
      .dividend(prod_ff), .divisor({timer_ff, 5'd0}),
      .sts(div_sts), .result(div_result)
   );

   assign req.ready = (state_ff == otm_pkg::ST_IDLE) && clear_done;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff; sum_in = sum_ff; mean_in = mean_ff;
      phase_in = phase_ff; snap_in = snap_ff; timer_in = timer_ff;
      accel_in = accel_ff; os_in = os_ff; oa_in = oa_ff; sf_in = sf_ff; al_in = al_ff;
      status_in = status_ff; upd_in = upd_ff;
      sample_in = sample_ff; ticks_in = ticks_ff; pu_in = pu_ff;
      prod_in = prod_ff; neg_in = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      ring_we = 1'b0;
      div_ctl = '0;
      tsum = {1'b0, timer_ff} + {{(otm_pkg::TimerW + 1 - otm_pkg::TicksW){1'b0}}, ticks_ff};
      dmag = (mean_ff < snap_ff) ? snap_ff - mean_ff : mean_ff - snap_ff;
      amag = accel_ff[otm_pkg::AccelW-1] ? 32'(-accel_ff) : 32'(accel_ff);
      avg_prod = AvgW'(sum_ff) * AvgW'(Recip);
      trip_now = 1'b0;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         otm_pkg::ST_IDLE: begin
            if (req.valid && clear_done) begin
               // choose the sample by the previous mean
               sample_in = (mean_ff < range_switch_ff) ? req.sample_low_range
                                                       : req.sample_high_range;
               ticks_in = req.elapsed_ticks;
               pu_in    = req.powerup_trip;
               state_in = otm_pkg::ST_READ;
            end
         end
         otm_pkg::ST_READ: begin
            // ring read data lands next cycle
            state_in = otm_pkg::ST_MEAN;
         end
         otm_pkg::ST_MEAN: begin
            ring_we = 1'b1;
            sum_in  = sum_ff - SumW'(ring_rd) + SumW'(sample_ff);
            idx_in  = (idx_ff == AW'(WINDOW_LEN - 1)) ? '0 : idx_ff + 1'b1;
            state_in = otm_pkg::ST_AVG;
            upd_in = 1'b0;
         end
         otm_pkg::ST_AVG: begin
            // mean of the ring from the updated running sum
            mean_in  = SW'(avg_prod >> RecK);
            state_in = otm_pkg::ST_DIVIDE;
         end
         otm_pkg::ST_DIVIDE: begin
            if (!phase_ff) begin
               snap_in = mean_ff; timer_in = '0; phase_in = 1'b1;
               state_in = otm_pkg::ST_CHECK;
            end else begin
               if (tsum[otm_pkg::TimerW]) timer_in = '1;
               else timer_in = tsum[otm_pkg::TimerW-1:0];
               if (timer_in > window_ticks_ff) begin
                  // register the product, then start the divider
                  prod_in  = otm_pkg::ProdW'(dmag) * otm_pkg::ProdW'(clock_hz_ff);
                  neg_in   = mean_ff < snap_ff;
                  upd_in   = 1'b1;
                  phase_in = 1'b0;
                  state_in = otm_pkg::ST_OUT;
               end else begin
                  state_in = otm_pkg::ST_CHECK;
               end
            end
         end
         otm_pkg::ST_OUT: begin
            // wait for the division
            if (!div_sts.busy && !div_sts.done && upd_ff) begin
               div_ctl.start = 1'b1;
               div_ctl.neg   = neg_ff;
            end
            if (div_sts.done) begin
               accel_in = div_result;
               state_in = otm_pkg::ST_CHECK;
            end
         end
         otm_pkg::ST_CHECK: begin
            if (!rsp_valid_ff || rsp.ready) begin
               status_in = status_ff;
               if (mean_ff > overspeed_limit_ff) begin
                  os_in = 1'b1; status_in = otm_pkg::STATUS_TRIPPED;
               end else if (mean_ff > alarm_limit_ff && status_ff != otm_pkg::STATUS_TRIPPED) begin
                  status_in = otm_pkg::STATUS_ALARM; al_in = 1'b1;
               end
               if (amag > {1'b0, accel_limit_ff}) begin
                  oa_in = 1'b1; status_in = otm_pkg::STATUS_TRIPPED;
               end
               if (pu_ff) status_in = otm_pkg::STATUS_TRIPPED;
               if (mean_ff < speed_fail_limit_ff) begin
                  sf_in = 1'b1; status_in = otm_pkg::STATUS_TRIPPED;
               end
               trip_now = os_in || oa_in || sf_in || pu_ff;
               if (!trip_now) status_in = otm_pkg::STATUS_NORMAL;
               rsp_valid_in = 1'b1;
               state_in = otm_pkg::ST_IDLE;
            end
         end
         default: state_in = otm_pkg::ST_IDLE;
      endcase
   end

   // the divider starts the cycle after the product is registered
   logic div_go_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= otm_pkg::ST_IDLE;
         idx_ff <= '0; sum_ff <= '0; mean_ff <= '0; phase_ff <= 1'b0;
         snap_ff <= '0; timer_ff <= '0; accel_ff <= '0;
         os_ff <= 1'b0; oa_ff <= 1'b0; sf_ff <= 1'b0; al_ff <= 1'b0;
         status_ff <= '0; upd_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         div_go_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in; sum_ff <= sum_in; mean_ff <= mean_in; phase_ff <= phase_in;
         snap_ff <= snap_in; timer_ff <= timer_in; accel_ff <= accel_in;
         os_ff <= os_in; oa_ff <= oa_in; sf_ff <= sf_in; al_ff <= al_in;
         status_ff <= status_in; upd_ff <= upd_in; rsp_valid_ff <= rsp_valid_in;
         div_go_ff <= (state_ff == otm_pkg::ST_DIVIDE) && (state_in == otm_pkg::ST_OUT);
      end
      sample_ff <= sample_in; ticks_ff <= ticks_in; pu_ff <= pu_in;
      prod_ff <= prod_in; neg_ff <= neg_in;
   end

   // hold the result beat
   logic [SW-1:0] o_mean_ff;
   logic signed [otm_pkg::AccelW-1:0] o_accel_ff;
   logic o_upd_ff, o_trip_ff, o_os_ff, o_oa_ff, o_sf_ff, o_al_ff;
   logic [1:0] o_status_ff;
   always_ff @(posedge clock) begin
      if (state_ff == otm_pkg::ST_CHECK && (!rsp_valid_ff || rsp.ready)) begin
         o_mean_ff <= mean_ff; o_accel_ff <= accel_ff; o_upd_ff <= upd_ff;
         o_trip_ff <= trip_now; o_os_ff <= os_in; o_oa_ff <= oa_in;
         o_sf_ff <= sf_in; o_al_ff <= al_in; o_status_ff <= status_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.average_speed = o_mean_ff;
   assign rsp.acceleration = o_accel_ff;
   assign rsp.accel_updated = o_upd_ff;
   assign rsp.trip = o_trip_ff;
   assign rsp.overspeed_flag = o_os_ff;
   assign rsp.overaccel_flag = o_oa_ff;
   assign rsp.speed_fail_flag = o_sf_ff;
   assign rsp.alarm_flag = o_al_ff;
   assign rsp.status = o_status_ff;

   // trip latches never clear outside reset
   a_os_sticky: assert property (@(posedge clock) disable iff (reset)
      os_ff |=> os_ff) else $error("overspeed latch cleared");
   a_oa_sticky: assert property (@(posedge clock) disable iff (reset)
      oa_ff |=> oa_ff) else $error("overaccel latch cleared");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != otm_pkg::ST_IDLE) |-> !req.ready) else $error("accept while busy");
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_go_ff |-> !div_sts.busy) else $error("divider restarted while busy");
endmodule

// ===== hdl/otm_ring.sv =====
// ----------------------------------------------------------------------------
// otm_ring: sample ring memory with a clearing pass after reset
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module otm_ring #(
   parameter int Depth = 100
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [$clog2(Depth)-1:0]      rd_addr,
   output logic [otm_pkg::SpeedW-1:0]    rd_data,
   input  logic                          wr_en,
   input  logic [$clog2(Depth)-1:0]      wr_addr,
   input  logic [otm_pkg::SpeedW-1:0]    wr_data,
   output logic                          clear_done
);
   localparam int AW = $clog2(Depth);

   logic [otm_pkg::SpeedW-1:0] mem [Depth];
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          clr_busy_ff, clr_busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == AW'(Depth - 1)) clr_busy_in = 1'b0;
         else clr_addr_in = clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // sweep zeros through the memory, then take normal writes
   always_ff @(posedge clock) begin
      if (clr_busy_ff) mem[clr_addr_ff] <= '0;
      else if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

   assign clear_done = !clr_busy_ff;
endmodule

// ===== hdl/otm_div.sv =====
// ----------------------------------------------------------------------------
// otm_div: restoring divider for the acceleration quotient
// One quotient bit per cycle; saturates to the signed 32-bit range.
// ----------------------------------------------------------------------------
module otm_div (
   input  logic                           clock,
   input  logic                           reset,
   input  otm_pkg::div_ctl_type           ctl,
   input  logic [otm_pkg::ProdW-1:0]      dividend,
   input  logic [otm_pkg::DenW-1:0]       divisor,
   output otm_pkg::div_sts_type           sts,
   output logic signed [otm_pkg::AccelW-1:0] result
);
   localparam int PW = otm_pkg::ProdW;
   localparam int DW = otm_pkg::DenW;
   localparam int CW = $clog2(PW + 1);

   logic [PW-1:0] quo_ff, quo_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          neg_ff, neg_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DW-1:0], quo_ff[PW-1]};
      diff    = trial - {1'b0, den_ff};
      if (ctl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CW'(PW);
         busy_in = 1'b1;
         neg_in  = ctl.neg;
      end else if (busy_ff) begin
         if (!diff[DW]) begin
            rem_in = diff;
            quo_in = {quo_ff[PW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[PW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      if (neg_ff) begin
         if (|quo_ff[PW-1:31]) result = 32'sh8000_0000;
         else result = -$signed({1'b0, quo_ff[30:0]});
      end else begin
         if (|quo_ff[PW-1:31]) result = 32'sh7FFF_FFFF;
         else result = $signed({1'b0, quo_ff[30:0]});
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
endmodule

// ===== verif/tb_overspeed_trip_monitor.sv =====
// ----------------------------------------------------------------------------
// tb_overspeed_trip_monitor: self-checking bench of the overspeed trip monitor
// A queue-fed driver pushes update beats with random gaps, a monitor takes
// result beats with random stalls, and a local predictor computes the
// expected mean, acceleration, trip latches and status of every beat.
// ----------------------------------------------------------------------------
module tb_overspeed_trip_monitor;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RingLen    = 100;
   localparam int WatchLimit = 20000;
   localparam int LongHold   = 400;
   localparam int SpeedW     = otm_pkg::SpeedW;
   localparam int TicksW     = otm_pkg::TicksW;
   localparam int AccelW     = otm_pkg::AccelW;
   localparam int AlimW      = otm_pkg::AlimW;
   localparam int ClockW     = otm_pkg::ClockW;
   localparam int TimerW     = otm_pkg::TimerW;
   localparam int CsrW       = otm_pkg::CsrW;
   localparam int CsrIdxW    = otm_pkg::CsrIdxW;

   typedef struct {
      bit [SpeedW-1:0] lo;
      bit [SpeedW-1:0] hi;
      bit [TicksW-1:0] ticks;
      bit              pu;
   } update_type;

   typedef struct {
      bit [SpeedW-1:0]        mean;
      bit signed [AccelW-1:0] accel;
      bit                     updated;
      bit                     trip;
      bit                     os;
      bit                     oa;
      bit                     sf;
      bit                     al;
      bit [1:0]               status;
   } reading_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrW-1:0] csr_data;

   otm_req_if req_if ();
   otm_rsp_if rsp_if ();

   overspeed_trip_monitor i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // free-running clock, 4 ns period
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // ------------------------------------------------------------------------
   // Predictor state: configuration copy plus the block's running state
   // ------------------------------------------------------------------------
   bit [SpeedW-1:0]  lim_overspeed, lim_alarm, lim_speed_fail, lim_range;
   bit [AlimW-1:0]   lim_accel;
   bit [ClockW-1:0]  tick_hz;
   bit [TimerW-1:0]  win_ticks;

   bit [SpeedW-1:0]        ring [RingLen];
   int                     ring_pos;
   bit [26:0]              ring_sum;
   bit [SpeedW-1:0]        mean_now;
   bit                     waiting_second;
   bit [SpeedW-1:0]        snap_speed;
   bit [TimerW-1:0]        win_timer;
   bit signed [AccelW-1:0] accel_now;
   bit                     os_l, oa_l, sf_l, al_l;
   otm_pkg::status_type    status_now;

   update_type  update_queue[$];
   reading_type awaited_results[$];

   int  n_updates, n_results, n_accel, n_errors, idle_cycles;
   bit  seen_os, seen_oa, seen_sf, seen_al, seen_sat;
   bit  no_idle, long_hold_req;

   // acceleration from two mean snapshots over a tick count, saturated
   function automatic bit signed [AccelW-1:0] accel_from(bit [SpeedW-1:0] s0,
         bit [SpeedW-1:0] s1, bit [TimerW-1:0] ticks);
      bit neg;
      longint unsigned mag, den, q;
      neg = s1 < s0;
      mag = neg ? 64'(s0 - s1) : 64'(s1 - s0);
      den = 64'(ticks) * 64'd32;
      if (den == 0) return '0;
      q = (mag * 64'(tick_hz)) / den;
      if (neg) begin
         if (q >= 64'h8000_0000) begin
            seen_sat = 1;
            return 32'h8000_0000;
         end
         return -$signed(32'(q));
      end
      if (q > 64'h7FFF_FFFF) begin
         seen_sat = 1;
         return 32'h7FFF_FFFF;
      end
      return $signed(32'(q));
   endfunction

   // advance the predicted state by one update and return its result
   function automatic reading_type predict_update(update_type u);
      reading_type r;
      bit [SpeedW-1:0] smp;
      bit [32:0] t;
      bit [31:0] amag;
      bit trip;
      smp = (mean_now < lim_range) ? u.lo : u.hi;
      ring_sum = ring_sum - 27'(ring[ring_pos]) + 27'(smp);
      ring[ring_pos] = smp;
      ring_pos = (ring_pos == RingLen - 1) ? 0 : ring_pos + 1;
      mean_now = 20'(ring_sum / RingLen);
      r.updated = 0;
      if (!waiting_second) begin
         snap_speed = mean_now;
         win_timer = '0;
         waiting_second = 1;
      end else begin
         t = 33'(win_timer) + 33'(u.ticks);
         win_timer = t[32] ? '1 : t[31:0];
         if (win_timer > win_ticks) begin
            accel_now = accel_from(snap_speed, mean_now, win_timer);
            r.updated = 1;
            waiting_second = 0;
         end
      end
      if (mean_now > lim_overspeed) begin
         os_l = 1;
         status_now = otm_pkg::STATUS_TRIPPED;
      end else if (mean_now > lim_alarm && status_now != otm_pkg::STATUS_TRIPPED) begin
         status_now = otm_pkg::STATUS_ALARM;
         al_l = 1;
      end
      amag = accel_now[31] ? 32'd0 - 32'(accel_now) : 32'(accel_now);
      if (amag > 32'(lim_accel)) begin
         oa_l = 1;
         status_now = otm_pkg::STATUS_TRIPPED;
      end
      if (u.pu) status_now = otm_pkg::STATUS_TRIPPED;
      if (mean_now < lim_speed_fail) begin
         sf_l = 1;
         status_now = otm_pkg::STATUS_TRIPPED;
      end
      trip = os_l | oa_l | sf_l | u.pu;
      if (!trip) status_now = otm_pkg::STATUS_NORMAL;
      r.mean = mean_now;
      r.accel = accel_now;
      r.trip = trip;
      r.os = os_l;
      r.oa = oa_l;
      r.sf = sf_l;
      r.al = al_l;
      r.status = status_now;
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------------
   // Driver: present beats at the falling edge, record acceptance at the rise
   // ------------------------------------------------------------------------
   update_type cur_update;
   bit         beat_taken;
   int         send_gap;

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         awaited_results.push_back(predict_update(cur_update));
         n_updates++;
         beat_taken = 1;
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_if.valid || beat_taken)) begin
         beat_taken = 0;
         if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (update_queue.size() > 0) begin
            cur_update = update_queue.pop_front();
            req_if.sample_low_range  <= cur_update.lo;
            req_if.sample_high_range <= cur_update.hi;
            req_if.elapsed_ticks     <= cur_update.ticks;
            req_if.powerup_trip      <= cur_update.pu;
            req_if.valid             <= 1'b1;
            send_gap = pick_gap();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: stall ready at random, check each result beat at the rise
   // ------------------------------------------------------------------------
   int hold_left;

   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (long_hold_req) begin
            // long hold-off: let the block fill up and stall its input
            long_hold_req = 0;
            hold_left = LongHold;
            rsp_if.ready <= 1'b0;
         end else begin
            hold_left = pick_gap();
            rsp_if.ready <= (hold_left == 0);
         end
      end
   end

   always @(posedge clock) begin
      reading_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         n_results++;
         if (awaited_results.size() == 0) begin
            $error("result beat with nothing expected");
            n_errors++;
         end else begin
            e = awaited_results.pop_front();
            if (rsp_if.average_speed !== e.mean) begin
               $error("average_speed: expected %0d, got %0d", e.mean, rsp_if.average_speed);
               n_errors++;
            end
            if (rsp_if.acceleration !== e.accel) begin
               $error("acceleration: expected %0d, got %0d", e.accel, rsp_if.acceleration);
               n_errors++;
            end
            if (rsp_if.accel_updated !== e.updated) begin
               $error("accel_updated: expected %0b, got %0b", e.updated,
                      rsp_if.accel_updated);
               n_errors++;
            end
            if (rsp_if.trip !== e.trip) begin
               $error("trip: expected %0b, got %0b", e.trip, rsp_if.trip);
               n_errors++;
            end
            if (rsp_if.overspeed_flag !== e.os) begin
               $error("overspeed_flag: expected %0b, got %0b", e.os, rsp_if.overspeed_flag);
               n_errors++;
            end
            if (rsp_if.overaccel_flag !== e.oa) begin
               $error("overaccel_flag: expected %0b, got %0b", e.oa, rsp_if.overaccel_flag);
               n_errors++;
            end
            if (rsp_if.speed_fail_flag !== e.sf) begin
               $error("speed_fail_flag: expected %0b, got %0b", e.sf,
                      rsp_if.speed_fail_flag);
               n_errors++;
            end
            if (rsp_if.alarm_flag !== e.al) begin
               $error("alarm_flag: expected %0b, got %0b", e.al, rsp_if.alarm_flag);
               n_errors++;
            end
            if (rsp_if.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_if.status);
               n_errors++;
            end
            n_accel += e.updated;
            seen_os |= e.os;
            seen_oa |= e.oa;
            seen_sf |= e.sf;
            seen_al |= e.al;
         end
      end
   end

   // watchdog: count cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
         $display("watchdog expired with %0d results outstanding", awaited_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic write_csr(otm_pkg::csr_index_type idx, bit [CsrW-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         otm_pkg::CSR_OVERSPEED:  lim_overspeed  = value[SpeedW-1:0];
         otm_pkg::CSR_ALARM:      lim_alarm      = value[SpeedW-1:0];
         otm_pkg::CSR_SPEED_FAIL: lim_speed_fail = value[SpeedW-1:0];
         otm_pkg::CSR_ACCEL:      lim_accel      = value[AlimW-1:0];
         otm_pkg::CSR_CLOCK:      tick_hz        = value[ClockW-1:0];
         otm_pkg::CSR_WINDOW:     win_ticks      = value;
         otm_pkg::CSR_RANGE:      lim_range      = value[SpeedW-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic add_update(int lo, int hi, int ticks, bit pu);
      update_type u;
      u.lo = SpeedW'(lo);
      u.hi = SpeedW'(hi);
      u.ticks = TicksW'(ticks);
      u.pu = pu;
      update_queue.push_back(u);
   endtask

   // hold the sender until every result is back, then allow the divider to settle
   task automatic drain();
      while (update_queue.size() > 0 || req_if.valid || awaited_results.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // samples spread around a center so the mean crosses the thresholds
   function automatic bit [SpeedW-1:0] speed_near(int center, int spread);
      int v;
      if ($urandom_range(0, 7) == 0) return SpeedW'($urandom());
      v = center + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 20'hFFFFF) v = 20'hFFFFF;
      return SpeedW'(v);
   endfunction

   function automatic int pick_ticks(int tmax);
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return 0;
      if (r < 6) return $urandom_range(0, tmax);
      if (r < 8) return $urandom_range(0, 24'hFFFFFF);
      return r == 8 ? 24'hFFFFFF : 1;
   endfunction

   task automatic random_updates(int n, int center, int spread, int tmax);
      repeat (n)
         add_update(int'(speed_near(center, spread)), int'(speed_near(center, spread)),
                    pick_ticks(tmax), $urandom_range(0, 15) == 0);
      drain();
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      lim_overspeed = 20'hFFFFF;
      lim_alarm = 20'hFFFFF;
      lim_speed_fail = '0;
      lim_accel = 31'h7FFFFFFF;
      tick_hz = 28'd120000000;
      win_ticks = 32'd5000000;
      lim_range = 20'd400000;
      ring_pos = 0;
      ring_sum = '0;
      mean_now = '0;
      waiting_second = 0;
      snap_speed = '0;
      win_timer = '0;
      accel_now = '0;
      {os_l, oa_l, sf_l, al_l} = '0;
      status_now = otm_pkg::STATUS_NORMAL;
      foreach (ring[i]) ring[i] = '0;

      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_if.valid = 1'b0;
      req_if.sample_low_range = '0;
      req_if.sample_high_range = '0;
      req_if.elapsed_ticks = '0;
      req_if.powerup_trip = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, both ranges, window close, power-up trip
      add_update(0, 0, 0, 0);
      add_update(20'hFFFFF, 20'hFFFFF, 24'hFFFFFF, 0);
      add_update(20'hFFFFF, 0, 0, 1);
      add_update(20'hFFFFF, 0, 1, 0);
      for (int i = 0; i < 12; i++) add_update(20'hFFFFF, 20'h00001, 24'h7FFFFF, 0);
      add_update(0, 20'hFFFFF, 24'hFFFFFF, 1);
      add_update(20'h55555, 20'hAAAAA, 24'h555555, 0);
      add_update(20'hAAAAA, 20'h55555, 24'hAAAAAA, 0);
      add_update(0, 0, 24'hFFFFFF, 0);
      add_update(0, 0, 24'hFFFFFF, 0);
      drain();

      // short window, mid clock: frequent recomputes, range switch crossing
      write_csr(otm_pkg::CSR_WINDOW, 32'd1000);
      write_csr(otm_pkg::CSR_CLOCK, 32'd50000);
      write_csr(otm_pkg::CSR_RANGE, 32'd300000);
      no_idle = 0;
      long_hold_req = 1;
      random_updates(400, 300000, 200000, 2000);

      // zero range switch: high range always; no idling stretch; alarm latch
      write_csr(otm_pkg::CSR_RANGE, 32'd0);
      write_csr(otm_pkg::CSR_ALARM, 32'd500000);
      write_csr(otm_pkg::CSR_WINDOW, 32'hFFFFFFFF);
      no_idle = 1;
      random_updates(150, 600000, 300000, 24'hFFFFFF);
      no_idle = 0;
      write_csr(otm_pkg::CSR_RANGE, 32'hFFFFF);
      write_csr(otm_pkg::CSR_CLOCK, 32'd0);
      write_csr(otm_pkg::CSR_WINDOW, 32'd1);
      random_updates(150, 500000, 400000, 4);

      // fastest clock, one-tick window: saturation both ways, accel trip
      write_csr(otm_pkg::CSR_CLOCK, 32'd200000000);
      write_csr(otm_pkg::CSR_RANGE, 32'd400000);
      random_updates(150, 400000, 400000, 3);
      write_csr(otm_pkg::CSR_ACCEL, 32'd0);
      write_csr(otm_pkg::CSR_CLOCK, 32'd1);
      write_csr(otm_pkg::CSR_WINDOW, 32'd100);
      random_updates(250, 200000, 200000, 200);

      // speed failure then overspeed latch
      write_csr(otm_pkg::CSR_SPEED_FAIL, 32'd100000);
      random_updates(200, 80000, 60000, 5000);
      write_csr(otm_pkg::CSR_SPEED_FAIL, 32'hFFFFF);
      write_csr(otm_pkg::CSR_OVERSPEED, 32'd0);
      write_csr(otm_pkg::CSR_CLOCK, 32'd120000000);
      write_csr(otm_pkg::CSR_WINDOW, 32'd5000000);
      random_updates(330, 524288, 524287, 24'hFFFFFF);

      $display("ran %0d updates, %0d results, %0d acceleration recomputes",
               n_updates, n_results, n_accel);
      $display("latches seen: overspeed %0b overaccel %0b speed fail %0b alarm %0b, sat %0b",
               seen_os, seen_oa, seen_sf, seen_al, seen_sat);
      if (n_errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
